@@ rtl/core/ils_pkg.sv @@
// Package for the indexed list store: transaction types, command codes,
// status codes and the broadcast command bundle. Depends on nothing.
package ils_pkg;

  // Default number of list slots.
  localparam int CAPACITY_DEF = 64;

  // Field widths fixed by the transaction format.
  localparam int OP_W     = 3;
  localparam int POS_W    = 16;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  // Command codes.
  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_HEAD   = 3'd1;
  localparam logic [OP_W-1:0] OP_TAIL   = 3'd2;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Value returned by a read that misses and by every other command.
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  // Input transaction.
  typedef struct packed {
    logic        [OP_W-1:0]  op;
    logic signed [POS_W-1:0] position;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic signed [VAL_W-1:0]    read_value;
    logic        [STATUS_W-1:0] status;
    logic        [LEN_W-1:0]    length;
  } out_item_t;

  // Command broadcast to every cell of the row at once.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [POS_W-1:0] slot;
    logic [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

@@ rtl/core/indexed_list_store.sv @@
// Top level of the indexed list store: command decode, entry count, result
// register and the row of cells. Depends on ils_pkg and ils_row.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_stall   ils_pkg::in_item_t
//   out_     output     out_valid/out_stall ils_pkg::out_item_t
//
// Each transaction is decoded and applied to the cell row in the cycle it is
// accepted; its result appears in the output register on the next cycle.
// One transaction per cycle is accepted while in_stall is low; every cell shifts or holds at once.
// Reset clears the entry count and the result valid flag; entries and result
// data are not reset.
// in_stall is raised only while a result is held back by out_stall.
module indexed_list_store #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ils_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ils_pkg::out_item_t  out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [ils_pkg::POS_W-1:0] CAP_POS = ils_pkg::POS_W'(CAPACITY);

  logic [CNT_W-1:0]              count_r;
  logic [CNT_W-1:0]              count_nxt;
  logic                          out_valid_r;
  ils_pkg::out_item_t            out_data_r;
  logic                          accept;
  logic [ils_pkg::POS_W-1:0]     cnt_pos;
  logic [ils_pkg::POS_W-1:0]     pos_mag;
  logic                          pos_neg;
  logic                          in_range;
  logic                          full;
  logic                          do_ins;
  logic                          do_del;
  logic [ils_pkg::POS_W-1:0]     slot;
  logic [ils_pkg::STATUS_W-1:0]  status;
  logic                          rd_ok;
  ils_pkg::cell_cmd_t            cmd;
  logic [ils_pkg::VAL_W-1:0]     rd_data;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign cnt_pos  = ils_pkg::POS_W'(count_r);
  assign pos_neg  = in_data.position[ils_pkg::POS_W-1];
  assign pos_mag  = {1'b0, in_data.position[ils_pkg::POS_W-2:0]};
  assign in_range = ~pos_neg & (pos_mag < cnt_pos);
  assign full     = (cnt_pos == CAP_POS);

  // Command decode: the slot the row acts on and the resulting status.
  always_comb begin
    do_ins = 1'b0;
    do_del = 1'b0;
    rd_ok  = 1'b0;
    slot   = pos_mag;
    status = ils_pkg::ST_RANGE;
    unique case (in_data.op)
      ils_pkg::OP_READ: begin
        if (in_range) begin
          rd_ok  = 1'b1;
          status = ils_pkg::ST_DONE;
        end
      end
      ils_pkg::OP_HEAD: begin
        slot   = '0;
        status = full ? ils_pkg::ST_FULL : ils_pkg::ST_DONE;
        do_ins = ~full;
      end
      ils_pkg::OP_TAIL: begin
        slot   = cnt_pos;
        status = full ? ils_pkg::ST_FULL : ils_pkg::ST_DONE;
        do_ins = ~full;
      end
      ils_pkg::OP_INSERT: begin
        if (pos_neg) begin
          slot   = '0;
          status = full ? ils_pkg::ST_FULL : ils_pkg::ST_DONE;
          do_ins = ~full;
        end else if (pos_mag <= cnt_pos) begin
          status = full ? ils_pkg::ST_FULL : ils_pkg::ST_DONE;
          do_ins = ~full;
        end
      end
      ils_pkg::OP_DELETE: begin
        if (in_range) begin
          status = ils_pkg::ST_DONE;
          do_del = 1'b1;
        end
      end
      default: begin
        status = ils_pkg::ST_RANGE;
      end
    endcase
  end

  assign cmd.ins   = accept & do_ins;
  assign cmd.del   = accept & do_del;
  assign cmd.slot  = slot;
  assign cmd.value = in_data.value;

  ils_row #(
    .CAPACITY(CAPACITY)
  ) u_row (
    .clk    (clk),
    .cmd    (cmd),
    .rd_data(rd_data)
  );

  // Entry count follows the accepted insert or delete.
  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register, loaded with each accepted transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.read_value <= rd_ok ? rd_data : ils_pkg::MISS_VALUE;
      out_data_r.status     <= status;
      out_data_r.length     <= ils_pkg::LEN_W'(count_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The count never runs past the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // A full store rejects the insert and keeps its count.
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && status == ils_pkg::ST_FULL) |=> $stable(count_r))
    else $error("count changed on a dropped insert");

  // A successful insert grows the count by one.
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the count");

  // Every accepted transaction leaves a result in the output register.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted transaction produced no result");

endmodule

@@ rtl/core/ils_cell.sv @@
// One slot of the list: holds a single entry and shifts with its neighbors.
// Depends on ils_pkg for the command bundle.
module ils_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  ils_pkg::cell_cmd_t        cmd,
  input  logic [ils_pkg::VAL_W-1:0] left_data,
  input  logic [ils_pkg::VAL_W-1:0] right_data,
  output logic [ils_pkg::VAL_W-1:0] data,
  output logic [ils_pkg::VAL_W-1:0] hit_data
);

  localparam logic [ils_pkg::POS_W-1:0] MY_IDX = ils_pkg::POS_W'(IDX);

  logic [ils_pkg::VAL_W-1:0] data_r;
  logic [ils_pkg::VAL_W-1:0] data_nxt;
  logic                      at_slot;
  logic                      past_slot;

  assign at_slot   = (MY_IDX == cmd.slot);
  assign past_slot = (MY_IDX > cmd.slot);

  // An insert opens a gap at the slot and writes the value into it, a delete closes the gap at the slot.
  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (past_slot) begin
        data_nxt = left_data;
      end else if (at_slot) begin
        data_nxt = cmd.value;
      end
    end else if (cmd.del) begin
      if (past_slot || at_slot) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data     = data_r;
  // Only the addressed cell drives its entry onto the read bus.
  assign hit_data = at_slot ? data_r : '0;

endmodule

@@ rtl/core/ils_row.sv @@
// Row of list cells chained to their neighbors, plus the OR bus that
// collects the entry of the addressed cell. Depends on ils_pkg and ils_cell.
module ils_row #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input  logic                      clk,
  input  ils_pkg::cell_cmd_t        cmd,
  output logic [ils_pkg::VAL_W-1:0] rd_data
);

  logic [ils_pkg::VAL_W-1:0] cell_data [CAPACITY];
  logic [ils_pkg::VAL_W-1:0] cell_hit  [CAPACITY];

  // Each cell takes from the cell in front on insert and from the one behind
  // on delete; the row ends feed back their own entry.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ils_cell #(
      .IDX(i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .left_data (cell_data[(i == 0) ? 0 : i-1]),
      .right_data(cell_data[(i == CAPACITY-1) ? i : i+1]),
      .data      (cell_data[i]),
      .hit_data  (cell_hit[i])
    );
  end

  // At most one cell matches the slot, so an OR merges the read bus.
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | cell_hit[i];
    end
  end

endmodule
